>>> src/ctt_pkg.sv
// Shared types, constants and defaults for the centroid track table.
`default_nettype none
package ctt_pkg;

  // Defaults for top-level parameters
  localparam int MAX_TRACKS_DEF  = 16;
  localparam int COORD_BITS_DEF  = 12;

  // Fixed field widths
  localparam int COORD_IN_W = 12;
  localparam int GATE_W     = 24;
  localparam int LIMIT_W    = 3;
  localparam int REP_W      = 3;
  localparam int CNT_OUT_W  = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register reset values
  localparam logic [GATE_W-1:0]  GATE_RESET  = 24'd2500;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd3;
  localparam logic [REP_W-1:0]   REPEAT_MAX  = 3'd7;
  localparam logic [REP_W-1:0]   REPEAT_ZERO = 3'd0;

  // Request codes
  localparam logic REQ_DETECT  = 1'b0;
  localparam logic REQ_ANALYZE = 1'b1;

  // Register select (word address bit 2)
  localparam logic REG_SEL_GATE  = 1'b0;
  localparam logic REG_SEL_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CREATE,
    ST_RESULT
  } ctt_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // latch input beat, clear per-item counters
    logic issue;     // read next slot
    logic create;    // start a new track in the first free slot
    logic load_out;  // move result into output register
  } ctt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;    // issuing the last slot
    logic pipe_busy;    // slot pipeline still holds work
    logic need_create;  // detect beat with no matching track
    logic out_free;     // output register can take a result
  } ctt_stat_t;

endpackage
`default_nettype wire

>>> src/ctt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/ctt_ctrl.sv
// Controller state machine: sequences one beat through scan, drain, create and result.
`default_nettype none
module ctt_ctrl
  import ctt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ctt_stat_t stat,
  output ctt_cmd_t       cmd
);

  ctt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = stat.need_create ? ST_CREATE : ST_RESULT;
        end
      end
      ST_CREATE: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_SCAN:   cmd.issue    = 1'b1;
      ST_DRAIN:  cmd          = '0;
      ST_CREATE: cmd.create   = 1'b1;
      ST_RESULT: cmd.load_out = stat.out_free;
      default:   cmd          = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/ctt_datapath.sv
// Datapath: slot scan pipeline, track memory, valid bits, counters, output register.
`default_nettype none
module ctt_datapath
  import ctt_pkg::*;
#(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctt_cmd_t              cmd,
  output ctt_stat_t                  stat,
  input  wire logic                  in_req_type,
  input  wire logic [COORD_IN_W-1:0] in_centroid_x,
  input  wire logic [COORD_IN_W-1:0] in_centroid_y,
  input  wire logic [GATE_W-1:0]     gate_radius_sq,
  input  wire logic [LIMIT_W-1:0]    repeat_limit,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CNT_OUT_W-1:0]       out_matched_count,
  output logic                       out_track_created,
  output logic                       out_table_full,
  output logic [CNT_OUT_W-1:0]       out_removed_count,
  output logic [CNT_OUT_W-1:0]       out_active_tracks
);

  localparam int IDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
  localparam int C      = COORD_BITS;
  localparam int DATA_W = 4 * C + REP_W;
  localparam int SQ_W   = 2 * C;
  localparam int CMP_W  = (SQ_W + 1 > GATE_W) ? SQ_W + 1 : GATE_W;
  localparam int EXT_W  = (C > COORD_IN_W) ? C : COORD_IN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TRACKS - 1);

  // Beat latched at accept
  logic         kind_r;
  logic [C-1:0] cx_r, cy_r;
  logic [C-1:0] cx_in, cy_in;

  assign cx_in = C'(EXT_W'(in_centroid_x));
  assign cy_in = C'(EXT_W'(in_centroid_y));

  // Scan pipeline registers
  logic [IDX_W-1:0]  issue_idx_r;
  logic              a_vld_r;
  logic [IDX_W-1:0]  a_idx_r;
  logic              b_vld_r;
  logic [IDX_W-1:0]  b_idx_r;
  logic [DATA_W-1:0] b_word_r;
  logic [SQ_W-1:0]   b_sqx_r, b_sqy_r;

  // Slot state and per-beat counters
  logic [MAX_TRACKS-1:0] valid_r;
  logic [CNT_W-1:0]      active_r, matched_r, removed_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic                  created_r, full_r;

  // Output register
  logic                 out_valid_r;
  logic [CNT_OUT_W-1:0] out_matched_r, out_removed_r, out_active_r;
  logic                 out_created_r, out_full_r;

  // Track memory
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  ctt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_TRACKS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.issue),
    .raddr (issue_idx_r),
    .rdata (ram_rdata)
  );

  // Stage A: absolute differences and squares from the read word
  logic [C-1:0] a_ex, a_ey, a_dx, a_dy;
  assign a_ex = ram_rdata[C-1:0];
  assign a_ey = ram_rdata[2*C-1:C];
  assign a_dx = (a_ex >= cx_r) ? a_ex - cx_r : cx_r - a_ex;
  assign a_dy = (a_ey >= cy_r) ? a_ey - cy_r : cy_r - a_ey;

  // Stage B: gate test or aging on the registered word
  logic [C-1:0]     b_ex, b_ey, b_pex, b_pey;
  logic [REP_W-1:0] b_rep, b_rep_nxt;
  logic             b_slot_v, b_hit, b_age, b_remove, b_unmoved;
  logic [CMP_W-1:0] b_dsq;

  assign b_ex     = b_word_r[C-1:0];
  assign b_ey     = b_word_r[2*C-1:C];
  assign b_pex    = b_word_r[3*C-1:2*C];
  assign b_pey    = b_word_r[4*C-1:3*C];
  assign b_rep    = b_word_r[DATA_W-1:4*C];
  assign b_slot_v = b_vld_r && valid_r[b_idx_r];
  assign b_dsq    = CMP_W'(b_sqx_r) + CMP_W'(b_sqy_r);
  assign b_hit    = b_slot_v && (kind_r == REQ_DETECT) &&
                    (b_dsq <= CMP_W'(gate_radius_sq));
  assign b_age    = b_slot_v && (kind_r == REQ_ANALYZE);
  assign b_unmoved = (b_ex == b_pex) && (b_ey == b_pey);
  assign b_rep_nxt = (b_unmoved && (b_rep != REPEAT_MAX)) ? b_rep + 3'd1 : b_rep;
  assign b_remove  = b_age && (b_rep_nxt >= repeat_limit);

  // Memory write: create, continue, or age
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = b_idx_r;
    ram_wdata = b_word_r;
    priority if (cmd.create) begin
      ram_we    = free_found_r;
      ram_waddr = free_idx_r;
      ram_wdata = {REPEAT_ZERO, cy_r, cx_r, cy_r, cx_r};
    end else if (b_hit) begin
      ram_we    = 1'b1;
      ram_wdata = {b_rep, b_ey, b_ex, cy_r, cx_r};
    end else if (b_age) begin
      ram_we    = 1'b1;
      ram_wdata = {b_rep_nxt, b_ey, b_ex, b_ey, b_ex};
    end
  end

  // Beat capture and pipeline advance
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r <= in_req_type;
      cx_r   <= cx_in;
      cy_r   <= cy_in;
    end
    a_idx_r  <= issue_idx_r;
    b_idx_r  <= a_idx_r;
    b_word_r <= ram_rdata;
    b_sqx_r  <= a_dx * a_dx;
    b_sqy_r  <= a_dy * a_dy;
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_idx_r  <= '0;
      a_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      valid_r      <= '0;
      active_r     <= '0;
      matched_r    <= '0;
      removed_r    <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      created_r    <= 1'b0;
      full_r       <= 1'b0;
    end else begin
      a_vld_r <= cmd.issue;
      b_vld_r <= a_vld_r;
      if (cmd.start) begin
        issue_idx_r  <= '0;
        matched_r    <= '0;
        removed_r    <= '0;
        free_found_r <= 1'b0;
        created_r    <= 1'b0;
        full_r       <= 1'b0;
      end else if (cmd.issue) begin
        issue_idx_r <= issue_idx_r + 1'b1;
      end
      // first free slot seen by the scan
      if (b_vld_r && !valid_r[b_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= b_idx_r;
      end
      if (b_hit) matched_r <= matched_r + 1'b1;
      if (b_remove) begin
        valid_r[b_idx_r] <= 1'b0;
        removed_r        <= removed_r + 1'b1;
        active_r         <= active_r - 1'b1;
      end
      if (cmd.create) begin
        created_r <= free_found_r;
        full_r    <= !free_found_r;
        if (free_found_r) begin
          valid_r[free_idx_r] <= 1'b1;
          active_r            <= active_r + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_matched_r <= CNT_OUT_W'((CNT_W + CNT_OUT_W)'(matched_r));
      out_removed_r <= CNT_OUT_W'((CNT_W + CNT_OUT_W)'(removed_r));
      out_active_r  <= CNT_OUT_W'((CNT_W + CNT_OUT_W)'(active_r));
      out_created_r <= created_r;
      out_full_r    <= full_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_matched_count = out_matched_r;
  assign out_removed_count = out_removed_r;
  assign out_active_tracks = out_active_r;
  assign out_track_created = out_created_r;
  assign out_table_full    = out_full_r;

  // Status to controller
  assign stat.scan_last   = cmd.issue && (issue_idx_r == LAST_IDX);
  assign stat.pipe_busy   = a_vld_r || b_vld_r;
  assign stat.need_create = (kind_r == REQ_DETECT) && (matched_r == '0);
  assign stat.out_free    = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

>>> src/centroid_track_table.sv
// Top level of the centroid track table: configuration registers and block wiring.
//
//  channel | direction | handshake           | beat contents
//  in_     | input     | in_valid / in_stall | req_type, centroid_x, centroid_y
//  out_    | output    | out_valid/out_stall | matched, created, full, removed, active
//  cfg_    | input     | APB, pready tied 1  | gate_radius_sq @0, repeat_limit @4
//
// Each beat scans all MAX_TRACKS slots, one slot read from the track memory per
// cycle through the two-stage read pipeline; a detect that matched nothing then
// starts a track or finds the table full before its result is loaded.
// A new input beat is taken as soon as the previous result sits in the output
// register, even while out_stall holds it there.
// Synchronous active-low reset clears all slot valid bits; no memory sweep.
`default_nettype none
module centroid_track_table
  import ctt_pkg::*;
#(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_req_type,
  input  wire logic [COORD_IN_W-1:0] in_centroid_x,
  input  wire logic [COORD_IN_W-1:0] in_centroid_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CNT_OUT_W-1:0]       out_matched_count,
  output logic                       out_track_created,
  output logic                       out_table_full,
  output logic [CNT_OUT_W-1:0]       out_removed_count,
  output logic [CNT_OUT_W-1:0]       out_active_tracks,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  logic [GATE_W-1:0]  gate_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               cfg_wr;
  ctt_cmd_t           cmd;
  ctt_stat_t          stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r  <= GATE_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_SEL_GATE:  gate_r  <= cfg_pwdata[GATE_W-1:0];
        REG_SEL_LIMIT: limit_r <= cfg_pwdata[LIMIT_W-1:0];
        default:       gate_r  <= gate_r;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (cfg_paddr[2])
      REG_SEL_GATE:  cfg_prdata = CFG_DATA_W'(gate_r);
      REG_SEL_LIMIT: cfg_prdata = CFG_DATA_W'(limit_r);
      default:       cfg_prdata = '0;
    endcase
  end

  ctt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ctt_datapath #(
    .MAX_TRACKS (MAX_TRACKS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_centroid_x     (in_centroid_x),
    .in_centroid_y     (in_centroid_y),
    .gate_radius_sq    (gate_r),
    .repeat_limit      (limit_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_matched_count (out_matched_count),
    .out_track_created (out_track_created),
    .out_table_full    (out_table_full),
    .out_removed_count (out_removed_count),
    .out_active_tracks (out_active_tracks)
  );

endmodule
`default_nettype wire

>>> src/ctt_checker.sv
// Port-level checks for the centroid track table, bound to the top level.
`default_nettype none
module ctt_checker
  import ctt_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [CNT_OUT_W-1:0] out_matched_count,
  input wire logic                 out_track_created,
  input wire logic                 out_table_full,
  input wire logic [CNT_OUT_W-1:0] out_removed_count,
  input wire logic [CNT_OUT_W-1:0] out_active_tracks
);

  // A held result beat stays valid and keeps its three counts
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched_count) &&
      $stable(out_removed_count) && $stable(out_active_tracks))
    else $error("result beat changed while stalled");

  // A new track and a full table exclude each other
  a_create_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_track_created && out_table_full))
    else $error("track_created and table_full both set");

  // Creating or failing to create only follows a centroid with no match
  a_create_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_track_created || out_table_full) |->
      out_matched_count == '0 && out_removed_count == '0)
    else $error("create/full reported with matches or removals");

  // Removals only come from an analyze tick, which matches nothing
  a_remove_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_removed_count != '0 |-> out_matched_count == '0)
    else $error("removals reported together with matches");

  // Input is not taken right after an accept: each beat needs a full scan
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

endmodule

bind centroid_track_table ctt_checker u_ctt_checker (.*);
`default_nettype wire

>>> bench/track_table_checker.sv
// Checker for the centroid track table: tracks the table, predicts each result beat and compares.
module track_table_checker
  import ctt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [COORD_IN_W-1:0] in_centroid_x,
  input  logic [COORD_IN_W-1:0] in_centroid_y,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [CNT_OUT_W-1:0]  out_matched_count,
  input  logic                  out_track_created,
  input  logic                  out_table_full,
  input  logic [CNT_OUT_W-1:0]  out_removed_count,
  input  logic [CNT_OUT_W-1:0]  out_active_tracks,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    errors,
  output int                    pending
);

  localparam int SLOTS = MAX_TRACKS_DEF;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] matched;
    logic                 created;
    logic                 full;
    logic [CNT_OUT_W-1:0] removed;
    logic [CNT_OUT_W-1:0] active;
  } track_summary_t;

  // Shadow copy of the registers and of the track table
  logic [GATE_W-1:0]     gate_q;
  logic [LIMIT_W-1:0]    limit_q;
  logic                  live[SLOTS];
  logic [COORD_IN_W-1:0] end_x[SLOTS];
  logic [COORD_IN_W-1:0] end_y[SLOTS];
  logic [COORD_IN_W-1:0] prev_x[SLOTS];
  logic [COORD_IN_W-1:0] prev_y[SLOTS];
  logic [REP_W-1:0]      repeats[SLOTS];

  track_summary_t awaited_summaries[$];

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Gate a centroid against the track ends, or age the table, and summarize
  task automatic update_track_model(input logic kind, input logic [COORD_IN_W-1:0] cx,
                                    input logic [COORD_IN_W-1:0] cy,
                                    output track_summary_t sum);
    int unsigned dx, dy, hits, gone, count;
    bit placed;
    hits   = 0;
    gone   = 0;
    count  = 0;
    placed = 1'b0;
    sum    = '0;
    if (kind == REQ_DETECT) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (live[i]) begin
          dx = (end_x[i] >= cx) ? end_x[i] - cx : cx - end_x[i];
          dy = (end_y[i] >= cy) ? end_y[i] - cy : cy - end_y[i];
          if (dx * dx + dy * dy <= gate_q) begin
            prev_x[i] = end_x[i];
            prev_y[i] = end_y[i];
            end_x[i]  = cx;
            end_y[i]  = cy;
            hits++;
          end
        end
      end
      // no track continued: open one in the lowest free slot
      if (hits == 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !live[i]) begin
            live[i]    = 1'b1;
            end_x[i]   = cx;
            end_y[i]   = cy;
            prev_x[i]  = cx;
            prev_y[i]  = cy;
            repeats[i] = REPEAT_ZERO;
            placed     = 1'b1;
          end
        end
        sum.created = placed;
        sum.full    = !placed;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (live[i]) begin
          if (end_x[i] == prev_x[i] && end_y[i] == prev_y[i]) begin
            if (repeats[i] < REPEAT_MAX) repeats[i]++;
          end else begin
            prev_x[i] = end_x[i];
            prev_y[i] = end_y[i];
          end
          if (repeats[i] >= limit_q) begin
            live[i] = 1'b0;
            gone++;
          end
        end
      end
    end
    for (int i = 0; i < SLOTS; i++) if (live[i]) count++;
    sum.matched = hits[CNT_OUT_W-1:0];
    sum.removed = gone[CNT_OUT_W-1:0];
    sum.active  = count[CNT_OUT_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    track_summary_t want, got;
    logic [CFG_DATA_W-1:0] reg_want;
    if (!rst_n) begin
      gate_q  = GATE_RESET;
      limit_q = LIMIT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        live[i] = 1'b0;
      end
      awaited_summaries.delete();
    end else begin
      // register access
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == REG_SEL_GATE) gate_q = cfg_pwdata[GATE_W-1:0];
          else limit_q = cfg_pwdata[LIMIT_W-1:0];
        end else begin
          reg_want = (cfg_paddr[2] == REG_SEL_GATE) ? CFG_DATA_W'(gate_q) : CFG_DATA_W'(limit_q);
          if (cfg_prdata !== reg_want)
            note_mismatch($sformatf("read at %0d gave %h, expected %h",
                                    cfg_paddr, cfg_prdata, reg_want));
        end
      end
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{out_matched_count, out_track_created, out_table_full,
                out_removed_count, out_active_tracks};
        if (awaited_summaries.size() == 0) begin
          note_mismatch("result beat with no prediction waiting");
        end else begin
          want = awaited_summaries.pop_front();
          if (got.matched !== want.matched)
            note_mismatch($sformatf("matched_count %0d, expected %0d", got.matched, want.matched));
          if (got.created !== want.created)
            note_mismatch($sformatf("track_created %0d, expected %0d", got.created, want.created));
          if (got.full !== want.full)
            note_mismatch($sformatf("table_full %0d, expected %0d", got.full, want.full));
          if (got.removed !== want.removed)
            note_mismatch($sformatf("removed_count %0d, expected %0d", got.removed, want.removed));
          if (got.active !== want.active)
            note_mismatch($sformatf("active_tracks %0d, expected %0d", got.active, want.active));
        end
      end
      // input beat: predict its result
      if (in_valid && !in_stall) begin
        update_track_model(in_req_type, in_centroid_x, in_centroid_y, want);
        awaited_summaries.insert(awaited_summaries.size(), want);
      end
    end
    pending = awaited_summaries.size();
  end

endmodule

>>> bench/centroid_track_table_tb.sv
// Testbench top for the centroid track table: clock, reset, stimulus, stalls and verdict.
module centroid_track_table_tb;
  import ctt_pkg::*;

  localparam int COORD_TOP       = (1 << COORD_IN_W) - 1;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 212;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RECENT_DEPTH    = 24;

  localparam logic [CFG_ADDR_W-1:0] ADDR_GATE  = {REG_SEL_GATE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_LIMIT = {REG_SEL_LIMIT, 2'b00};

  typedef struct packed {
    logic [COORD_IN_W-1:0] x;
    logic [COORD_IN_W-1:0] y;
  } point_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic                  in_req_type   = REQ_DETECT;
  logic [COORD_IN_W-1:0] in_centroid_x = '0;
  logic [COORD_IN_W-1:0] in_centroid_y = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [CNT_OUT_W-1:0]  out_matched_count;
  logic                  out_track_created;
  logic                  out_table_full;
  logic [CNT_OUT_W-1:0]  out_removed_count;
  logic [CNT_OUT_W-1:0]  out_active_tracks;
  logic                  cfg_psel      = 1'b0;
  logic                  cfg_penable   = 1'b0;
  logic                  cfg_pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr     = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata    = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int errors;
  int pending;

  // idling knobs in percent of cycles, jitter span and hold-off requests
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int near_span     = 60;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  point_t recent_points[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  centroid_track_table DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_centroid_x     (in_centroid_x),
    .in_centroid_y     (in_centroid_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_matched_count (out_matched_count),
    .out_track_created (out_track_created),
    .out_table_full    (out_table_full),
    .out_removed_count (out_removed_count),
    .out_active_tracks (out_active_tracks),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  track_table_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_centroid_x     (in_centroid_x),
    .in_centroid_y     (in_centroid_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_matched_count (out_matched_count),
    .out_track_created (out_track_created),
    .out_table_full    (out_table_full),
    .out_removed_count (out_removed_count),
    .out_active_tracks (out_active_tracks),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .errors            (errors),
    .pending           (pending)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  always @(negedge clk) begin
    if (hold_left == 0 && holds_served < hold_requests) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    #12000000;
    $display("centroid_track_table_tb failed");
    $finish;
  end

  // Register write: setup cycle then access cycle
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic read_reg(input logic [CFG_ADDR_W-1:0] addr);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = addr;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Offer one beat and hold it until the block takes it; called at a falling edge
  task automatic send_beat(input logic kind, input logic [COORD_IN_W-1:0] cx,
                           input logic [COORD_IN_W-1:0] cy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_req_type   = kind;
    in_centroid_x = cx;
    in_centroid_y = cy;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (kind == REQ_DETECT) begin
      recent_points.insert(recent_points.size(), '{cx, cy});
      if (recent_points.size() > RECENT_DEPTH) void'(recent_points.pop_front());
    end
  endtask

  // Block goes idle once every predicted result has come out
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [COORD_IN_W-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_TOP) return COORD_IN_W'(COORD_TOP);
    return v[COORD_IN_W-1:0];
  endfunction

  // Analyze ticks, centroids that continue recent tracks, some repeats, edges and noise
  task automatic offer_random_item();
    int pick, jx, jy;
    point_t p;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_beat(REQ_ANALYZE, COORD_IN_W'($urandom_range(0, COORD_TOP)),
                COORD_IN_W'($urandom_range(0, COORD_TOP)));
    end else if (pick < 65 && recent_points.size() > 0) begin
      p  = recent_points[$urandom_range(0, recent_points.size() - 1)];
      jx = int'(p.x) + int'($urandom_range(0, 2 * near_span)) - near_span;
      jy = int'(p.y) + int'($urandom_range(0, 2 * near_span)) - near_span;
      send_beat(REQ_DETECT, clamp_coord(jx), clamp_coord(jy));
    end else if (pick < 75 && recent_points.size() > 0) begin
      p = recent_points[$urandom_range(0, recent_points.size() - 1)];
      send_beat(REQ_DETECT, p.x, p.y);
    end else if (pick < 80) begin
      send_beat(REQ_DETECT, COORD_IN_W'($urandom_range(0, 1) ? COORD_TOP : 0),
                COORD_IN_W'($urandom_range(0, 1) ? COORD_TOP : 0));
    end else begin
      send_beat(REQ_DETECT, COORD_IN_W'($urandom_range(0, COORD_TOP)),
                COORD_IN_W'($urandom_range(0, COORD_TOP)));
    end
  endtask

  initial begin
    int gate_val, limit_val;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset values, then tracks at the exact gate boundary and just past it
    read_reg(ADDR_GATE);
    read_reg(ADDR_LIMIT);
    send_beat(REQ_DETECT, 0, 0);
    send_beat(REQ_DETECT, 30, 40);
    send_beat(REQ_DETECT, 61, 80);
    send_beat(REQ_DETECT, 61, 80);
    send_beat(REQ_ANALYZE, 0, 0);
    send_beat(REQ_ANALYZE, COORD_IN_W'(COORD_TOP), COORD_IN_W'(COORD_TOP));
    send_beat(REQ_ANALYZE, 0, 0);
    wait_drained();

    // zero gate and stray upper bits: fill every slot, then a new point and a repeat
    write_reg(ADDR_GATE, 32'hFF00_0000);
    write_reg(ADDR_LIMIT, 32'hFFFF_FFFF);
    read_reg(ADDR_GATE);
    read_reg(ADDR_LIMIT);
    for (int i = 0; i < MAX_TRACKS_DEF; i++) begin
      send_beat(REQ_DETECT, COORD_IN_W'(i * 273), COORD_IN_W'(COORD_TOP - i * 273));
    end
    send_beat(REQ_DETECT, 2048, 1000);
    send_beat(REQ_DETECT, 0, COORD_IN_W'(COORD_TOP));
    wait_drained();

    // widest gate: one centroid continues every track
    write_reg(ADDR_GATE, 32'h00FF_FFFF);
    send_beat(REQ_DETECT, 2048, 2048);
    wait_drained();

    // limit of zero clears the whole table on the next tick
    write_reg(ADDR_LIMIT, 32'hFFFF_FFF8);
    read_reg(ADDR_LIMIT);
    send_beat(REQ_ANALYZE, 0, 0);
    send_beat(REQ_DETECT, COORD_IN_W'(COORD_TOP), 0);
    send_beat(REQ_ANALYZE, 0, 0);
    wait_drained();

    // random phases, each with its own settings and idling pattern
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          gate_val = 2500; limit_val = 3; near_span = 60;
          send_idle_pct = 0; stall_pct = 0;
        end
        1: begin
          gate_val = $urandom_range(0, 400); limit_val = 1; near_span = 25;
          send_idle_pct = 87; stall_pct = 0;
        end
        2: begin
          gate_val = 0; limit_val = 7; near_span = 2;
          send_idle_pct = 0; stall_pct = 87;
        end
        3: begin
          gate_val = 24'hFF_FFFF; limit_val = $urandom_range(1, 7); near_span = 500;
          send_idle_pct = 13; stall_pct = 13;
        end
        4: begin
          gate_val = $urandom_range(0, 20000); limit_val = $urandom_range(1, 7); near_span = 160;
          send_idle_pct = 0; stall_pct = 0;
        end
        5: begin
          gate_val = 2500; limit_val = 2; near_span = 60;
          send_idle_pct = 87; stall_pct = 0;
        end
        6: begin
          gate_val = $urandom_range(0, 65535); limit_val = $urandom_range(1, 7); near_span = 300;
          send_idle_pct = 0; stall_pct = 87;
        end
        default: begin
          gate_val = 900; limit_val = 5; near_span = 35;
          send_idle_pct = 13; stall_pct = 13;
        end
      endcase
      write_reg(ADDR_GATE, CFG_DATA_W'(gate_val));
      write_reg(ADDR_LIMIT, CFG_DATA_W'(limit_val));
      read_reg(ADDR_GATE);
      read_reg(ADDR_LIMIT);
      // block fills up behind a long receiver hold-off
      if (phase == 4) hold_requests++;
      repeat (ITEMS_PER_PHASE) offer_random_item();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("centroid_track_table_tb passed");
    end else begin
      $display("centroid_track_table_tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/ctt_pkg.sv
src/ctt_ram.sv
src/ctt_ctrl.sv
src/ctt_datapath.sv
src/centroid_track_table.sv
src/ctt_checker.sv
bench/track_table_checker.sv
bench/centroid_track_table_tb.sv
